// ===== sv/aes128_pkg.sv =====
// package for the aes-128 block encryption pipeline
// holds the block type, the s-box table, the round constants and the round functions
// no dependencies
`default_nettype none

package aes128_pkg;

   localparam int unsigned BlockBits = 128;
   localparam int unsigned HalfBits  = 64;
   localparam int unsigned NumRounds = 10;

   // byte 0 of the block sits in the top byte, index 15
   typedef logic [15:0][7:0] block_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   localparam logic [7:0] RCON [NumRounds] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   localparam logic [7:0] PolyLow = 8'h1b;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? PolyLow : 8'h00);
   endfunction

   // s-box lookup then row rotation
   function automatic block_type sub_shift(input block_type st);
      block_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[15 - (r + 4 * c)] = SBOX[st[15 - (r + 4 * ((c + r) % 4))]];
         end
      end
      sub_shift = t;
   endfunction

   function automatic block_type mix_columns(input block_type st);
      block_type t;
      logic [7:0] a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         a0  = st[15 - 4 * c];
         a1  = st[14 - 4 * c];
         a2  = st[13 - 4 * c];
         a3  = st[12 - 4 * c];
         all = a0 ^ a1 ^ a2 ^ a3;
         t[15 - 4 * c] = a0 ^ all ^ xtime(a0 ^ a1);
         t[14 - 4 * c] = a1 ^ all ^ xtime(a1 ^ a2);
         t[13 - 4 * c] = a2 ^ all ^ xtime(a2 ^ a3);
         t[12 - 4 * c] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      mix_columns = t;
   endfunction

   function automatic block_type next_key(input block_type rk, input logic [7:0] rcon);
      block_type  k;
      logic [3:0][7:0] t;
      t[3] = SBOX[rk[15 - 13]] ^ rcon;
      t[2] = SBOX[rk[15 - 14]];
      t[1] = SBOX[rk[15 - 15]];
      t[0] = SBOX[rk[15 - 12]];
      k = rk;
      for (int j = 0; j < 4; j++) begin
         k[15 - j] = rk[15 - j] ^ t[3 - j];
      end
      for (int w = 1; w < 4; w++) begin
         for (int j = 0; j < 4; j++) begin
            k[15 - (4 * w + j)] = k[15 - (4 * w + j)] ^ k[15 - (4 * (w - 1) + j)];
         end
      end
      next_key = k;
   endfunction

endpackage

`default_nettype wire

// ===== sv/aes128_round.sv =====
// one round cell of the encryption chain: round function plus on-the-fly key step
// depends on aes128_pkg
`default_nettype none

module aes128_round #(
   parameter logic [7:0] RoundConst = 8'h01,
   parameter bit         LastRound  = 1'b0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire aes128_pkg::block_type in_state,
   input  wire aes128_pkg::block_type in_key,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output aes128_pkg::block_type      out_state,
   output aes128_pkg::block_type      out_key
);

   logic                  valid_ff, valid_in;
   aes128_pkg::block_type state_ff, state_in;
   aes128_pkg::block_type key_ff, key_in;
   aes128_pkg::block_type shifted;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      shifted  = aes128_pkg::sub_shift(in_state);
      key_in   = aes128_pkg::next_key(in_key, RoundConst);
      state_in = (LastRound ? shifted : aes128_pkg::mix_columns(shifted)) ^ key_in;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         state_ff <= state_in;
         key_ff   <= key_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
   assign out_key   = key_ff;

endmodule

`default_nettype wire

// ===== sv/aes128_block_encrypt.sv =====
// top level of the aes-128 encryption pipeline with its key registers
// depends on aes128_pkg and aes128_round
`default_nettype none

// Encrypts one 128-bit block per cycle, unless back-pressure stalls it, under
// the key held in key_hi (0x0) and key_lo (0x8). An input register applies the
// initial key, then a chain of ten round cells each does one round and one key
// expansion step and registers it; the throughput is one block a cycle, set by
// the one-round-per-cell chain. Back-pressure stalls the chain per cell.
// Change the key only when no block is in flight.
module aes128_block_encrypt (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,  // plaintext_hi [63:0], plaintext_lo [127:64]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,  // ciphertext_hi [63:0], ciphertext_lo [127:64]
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [63:0]  csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int unsigned N = aes128_pkg::NumRounds;

   logic [63:0] key_hi_ff, key_lo_ff;
   logic        csr_write;

   logic                  s0_valid_ff, s0_valid_in;
   aes128_pkg::block_type s0_state_ff, s0_key_ff;
   aes128_pkg::block_type blk_in, key_blk;

   logic                  valid_w [N + 1];
   logic                  ready_w [N + 1];
   aes128_pkg::block_type state_w [N + 1];
   aes128_pkg::block_type key_w   [N + 1];

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_paddr[3] ? key_lo_ff : key_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
      end else if (csr_write) begin
         if (csr_paddr[3]) begin
            key_lo_ff <= csr_pwdata;
         end else begin
            key_hi_ff <= csr_pwdata;
         end
      end
   end

   // initial add-key stage
   assign blk_in     = {req_tdata[63:0], req_tdata[127:64]};
   assign key_blk    = {key_hi_ff, key_lo_ff};
   assign req_tready = !s0_valid_ff || ready_w[0];
   assign s0_valid_in = req_tready ? req_tvalid : s0_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s0_state_ff <= blk_in ^ key_blk;
         s0_key_ff   <= key_blk;
      end
   end

   assign valid_w[0] = s0_valid_ff;
   assign state_w[0] = s0_state_ff;
   assign key_w[0]   = s0_key_ff;

   for (genvar i = 0; i < N; i++) begin : g_round
      aes128_round #(
         .RoundConst (aes128_pkg::RCON[i]),
         .LastRound  (i == N - 1)
      ) u_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_w[i]),
         .in_ready  (ready_w[i]),
         .in_state  (state_w[i]),
         .in_key    (key_w[i]),
         .out_valid (valid_w[i + 1]),
         .out_ready (ready_w[i + 1]),
         .out_state (state_w[i + 1]),
         .out_key   (key_w[i + 1])
      );
   end

   assign ready_w[N]  = rsp_tready;
   assign rsp_tvalid  = valid_w[N];
   assign rsp_tdata   = {state_w[N][7:0], state_w[N][15:8]};

endmodule

`default_nettype wire

// ===== sv/aes128_checker.sv =====
// port-level checks for the aes-128 encryption pipeline, bound to the top level
// no package dependencies
`default_nettype none

module aes128_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [127:0] rsp_tdata,
   input wire logic         csr_psel,
   input wire logic         csr_penable,
   input wire logic         csr_pwrite,
   input wire logic [3:0]   csr_paddr,
   input wire logic [63:0]  csr_pwdata,
   input wire logic [63:0]  csr_prdata
);

   // a free output side never stalls the input
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready) else $error("input stalled with output ready");

   // nothing comes out straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid) else $error("result right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // a written key reads back in the next cycle
   a_key_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite |=>
         (csr_paddr[3] != $past(csr_paddr[3])) || (csr_prdata == $past(csr_pwdata)))
      else $error("key register readback mismatch");

endmodule

bind aes128_block_encrypt aes128_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);

`default_nettype wire

// ===== bench/tb_aes128_block_encrypt.sv =====
// self-checking bench for the aes-128 block encryption pipeline
// drives plaintext items and key writes, predicts every ciphertext and compares it
// depends on aes128_block_encrypt
`default_nettype none

module tb_aes128_block_encrypt;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] AddrKeyHi = 4'h0;
   localparam logic [3:0] AddrKeyLo = 4'h8;
   localparam int unsigned Latency   = 11;
   localparam int unsigned CycleLimit = 200000;

   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
   } half_pair_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // plaintext_hi [63:0], plaintext_lo [127:64]
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // ciphertext_hi [63:0], ciphertext_lo [127:64]
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [3:0]   csr_paddr;
   logic [63:0]  csr_pwdata;
   logic [63:0]  csr_prdata;
   logic         csr_pready;

   aes128_block_encrypt DUT (.*);

   half_pair_type plain_q[$];
   half_pair_type cipher_q[$];
   logic [63:0] key_hi_now, key_lo_now;
   logic [7:0]  sbox_calc [256];
   int unsigned fails, blocks_sent, blocks_checked, cycles;
   int unsigned burst_left, gap_left, max_gap, hold_req, hold_seen, hold_left, stall_pct;
   bit          keep_idle;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // gf(2^8) helpers for the predictor
   function automatic logic [7:0] gf_dbl(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 7; i >= 0; i--) begin
         acc = gf_dbl(acc);
         if (b[i]) acc = acc ^ a;
      end
      return acc;
   endfunction

   function automatic logic [7:0] sbox_entry(input logic [7:0] a);
      logic [7:0] inv, base;
      int unsigned e;
      inv = 8'h01;
      base = a;
      e = 254;
      // a^254: inverse, and zero maps to zero
      while (e != 0) begin
         if (e[0]) inv = gf_mul(inv, base);
         base = gf_mul(base, base);
         e = e >> 1;
      end
      return 8'h63 ^ inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
             ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]};
   endfunction

   function automatic half_pair_type encrypt_block(input half_pair_type pt,
                                                   input logic [63:0] khi,
                                                   input logic [63:0] klo);
      logic [7:0] st [16];
      logic [7:0] rk [16];
      logic [7:0] t [16];
      logic [7:0] w [4];
      logic [7:0] rc, a0, a1, a2, a3, all;
      half_pair_type ct;
      for (int i = 0; i < 8; i++) begin
         st[i]     = pt.hi[63 - 8 * i -: 8];
         st[i + 8] = pt.lo[63 - 8 * i -: 8];
         rk[i]     = khi[63 - 8 * i -: 8];
         rk[i + 8] = klo[63 - 8 * i -: 8];
      end
      rc = 8'h01;
      for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[i];
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               t[r + 4 * c] = sbox_calc[st[r + 4 * ((c + r) % 4)]];
         st = t;
         if (rnd < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = st[4 * c];
               a1 = st[4 * c + 1];
               a2 = st[4 * c + 2];
               a3 = st[4 * c + 3];
               all = a0 ^ a1 ^ a2 ^ a3;
               st[4 * c]     = a0 ^ all ^ gf_dbl(a0 ^ a1);
               st[4 * c + 1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
               st[4 * c + 2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
               st[4 * c + 3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
            end
         end
         // key schedule: rotated, substituted last word plus round constant
         w[0] = sbox_calc[rk[13]] ^ rc;
         w[1] = sbox_calc[rk[14]];
         w[2] = sbox_calc[rk[15]];
         w[3] = sbox_calc[rk[12]];
         for (int j = 0; j < 4; j++) rk[j] = rk[j] ^ w[j];
         for (int k = 4; k < 16; k++) rk[k] = rk[k] ^ rk[k - 4];
         rc = gf_dbl(rc);
         for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[i];
      end
      for (int i = 0; i < 8; i++) begin
         ct.hi[63 - 8 * i -: 8] = st[i];
         ct.lo[63 - 8 * i -: 8] = st[i + 8];
      end
      return ct;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h (block %0d)", what, got, want, blocks_checked);
      fails++;
   endtask

   // driver
   always @(posedge clock) begin
      half_pair_type nxt;
      logic          nv;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            cipher_q.push_back(encrypt_block({req_tdata[63:0], req_tdata[127:64]},
                                             key_hi_now, key_lo_now));
            blocks_sent++;
         end
         if (!req_tvalid || req_tready) begin
            nv = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (plain_q.size() > 0) begin
               nxt = plain_q.pop_front();
               nv = 1'b1;
               req_tdata <= {nxt.lo, nxt.hi};
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 20);
                  gap_left = keep_idle ? 0 : $urandom_range(0, max_gap);
               end
            end
            req_tvalid <= nv;
         end
      end
   end

   // receiver: random stalls plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      half_pair_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[63:0], rsp_tdata[127:64]};
         if (cipher_q.size() == 0) begin
            $display("unexpected result item %h", rsp_tdata);
            fails++;
         end else begin
            want = cipher_q.pop_front();
            if (got.hi !== want.hi) report_mismatch("ciphertext_hi", got.hi, want.hi);
            if (got.lo !== want.lo) report_mismatch("ciphertext_lo", got.lo, want.lo);
         end
         blocks_checked++;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, cipher_q.size());
         $display("** aes128_block_encrypt: FAILED **");
         $finish;
      end
   end

   task automatic wait_drained();
      while (plain_q.size() > 0 || req_tvalid || cipher_q.size() > 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   task automatic write_key(input logic [3:0] addr, input logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == AddrKeyHi) key_hi_now = value;
      else key_lo_now = value;
   endtask

   task automatic set_key(input logic [63:0] khi, input logic [63:0] klo);
      wait_drained();
      write_key(AddrKeyHi, khi);
      write_key(AddrKeyLo, klo);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic queue_random(input int unsigned n);
      half_pair_type p;
      for (int i = 0; i < n; i++) begin
         p.hi = rand64();
         p.lo = rand64();
         case ($urandom_range(0, 9))
            0: p.hi = '0;
            1: p.lo = '1;
            default: ;
         endcase
         plain_q.push_back(p);
      end
   endtask

   initial begin
      fails = 0; blocks_sent = 0; blocks_checked = 0; cycles = 0;
      burst_left = 0; gap_left = 0; max_gap = 4; keep_idle = 1'b0;
      hold_req = 0; hold_seen = 0; hold_left = 0; stall_pct = 20;
      key_hi_now = '0; key_lo_now = '0;
      clock = 1'b0;
      reset = 1'b1;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      for (int i = 0; i < 256; i++) sbox_calc[i] = sbox_entry(i[7:0]);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part under the reset key of zero: zero bytes hit s(0)
      plain_q.push_back('{'0, '0});
      plain_q.push_back('{'1, '1});
      plain_q.push_back('{64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001});
      plain_q.push_back('{64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555});
      plain_q.push_back('{64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210});

      // standard test vector
      set_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
      plain_q.push_back('{64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff});
      plain_q.push_back('{'0, '0});
      plain_q.push_back('{'1, '0});
      plain_q.push_back('{'0, '1});

      set_key('1, '1);
      plain_q.push_back('{'0, '0});
      plain_q.push_back('{'1, '1});
      plain_q.push_back('{64'h0000_0000_ffff_ffff, 64'hffff_ffff_0000_0000});

      // key changes straight after traffic, including back to zero
      set_key('0, '1);
      plain_q.push_back('{64'hdead_beef_0000_0000, '0});
      set_key('1, '0);
      plain_q.push_back('{'0, 64'h0000_0000_dead_beef});
      set_key('0, '0);
      plain_q.push_back('{64'h6bc1_bee2_2e40_9f96, 64'he93d_7e11_7393_172a});

      // back-pressure: long hold-off while the sender keeps offering
      set_key(rand64(), rand64());
      keep_idle = 1'b1;
      hold_req++;
      queue_random(90);

      // random phases, from no idling to heavy stalls
      for (int ph = 0; ph < 5; ph++) begin
         set_key(rand64(), rand64());
         keep_idle = (ph == 0);
         max_gap   = (ph == 4) ? 12 : 4;
         stall_pct = (ph == 0) ? 0 : $urandom_range(10, 70);
         queue_random(90);
      end
      wait_drained();

      $display("%0d blocks encrypted and %0d results checked", blocks_sent, blocks_checked);
      $display("covered zero, all-ones and random keys, the standard vector and stalls");
      if (fails == 0) begin
         $display("** aes128_block_encrypt: PASSED **");
      end else begin
         $display("** aes128_block_encrypt: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
